// ===== hw/rtl/lc3sic_pkg.sv =====
// ----------------------------------------------------------------------------
// lc3sic_pkg
// Shared types, codes and helpers for the LC-3 subset instruction core.
// ----------------------------------------------------------------------------
package lc3sic_pkg;

  // item kinds on the input channel
  typedef enum logic [1:0] {
    KIND_LOAD = 2'd0,
    KIND_STEP = 2'd1,
    KIND_SET  = 2'd2
  } kind_e;

  // opcodes that do something; all others act as no-ops
  typedef enum logic [3:0] {
    OP_BR   = 4'h0,
    OP_ADD  = 4'h1,
    OP_LD   = 4'h2,
    OP_ST   = 4'h3,
    OP_AND  = 4'h5,
    OP_NOT  = 4'h9,
    OP_JMP  = 4'hC,
    OP_TRAP = 4'hF
  } opcode_e;

  localparam logic [15:0] PC_RESET   = 16'h3000;
  localparam logic [15:0] BASE_RESET = 16'h3000;

  // condition flag bit positions
  localparam int unsigned CC_N = 2;
  localparam int unsigned CC_Z = 1;
  localparam int unsigned CC_P = 0;

  // decision of the execute stage for one item
  typedef struct packed {
    logic        step;
    logic [15:0] next_pc;
    logic        reg_we;
    logic [2:0]  reg_idx;
    logic [15:0] reg_val;
    logic        mem_we;
    logic [15:0] mem_addr;
    logic [15:0] mem_data;
    logic [2:0]  flags;
    logic        trap;
    logic [7:0]  trap_vec;
  } exec_t;

  // n/z/p from a 16-bit result read as signed
  function automatic logic [2:0] cc_of(input logic [15:0] v);
    logic [2:0] cc;
    cc = 3'b000;
    if (v == 16'h0000) begin
      cc[CC_Z] = 1'b1;
    end else if (v[15]) begin
      cc[CC_N] = 1'b1;
    end else begin
      cc[CC_P] = 1'b1;
    end
    return cc;
  endfunction

endpackage

// ===== hw/rtl/lc3sic_if.sv =====
// ----------------------------------------------------------------------------
// lc3sic_if
// Valid/ready channels of the LC-3 subset core: command in, result out.
// ----------------------------------------------------------------------------

// command channel
interface lc3sic_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [15:0] address;
  logic [15:0] data;

  modport source (output valid, output kind, output address, output data, input ready);
  modport sink   (input valid, input kind, input address, input data, output ready);
endinterface

// result channel
interface lc3sic_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] pc;
  logic [15:0] instr;
  logic        flag_n;
  logic        flag_z;
  logic        flag_p;
  logic        halted;
  logic [7:0]  trap_code;
  logic        reg_written;
  logic [2:0]  reg_index;
  logic [15:0] reg_value;
  logic        mem_written;

  modport source (
    output valid, output pc, output instr, output flag_n, output flag_z, output flag_p,
    output halted, output trap_code, output reg_written, output reg_index,
    output reg_value, output mem_written, input ready
  );
  modport sink (
    input valid, input pc, input instr, input flag_n, input flag_z, input flag_p,
    input halted, input trap_code, input reg_written, input reg_index,
    input reg_value, input mem_written, output ready
  );
endinterface

// ===== hw/rtl/lc3sic_mem.sv =====
// ----------------------------------------------------------------------------
// lc3sic_mem
// Word store behind a relocatable address window, with per-word valid bits.
// ----------------------------------------------------------------------------
module lc3sic_mem #(
  parameter int unsigned MEM_WORDS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [15:0] base_i,
  input  logic [15:0] rd_a_addr_i,
  output logic [15:0] rd_a_data_o,
  input  logic [15:0] rd_b_addr_i,
  output logic [15:0] rd_b_data_o,
  input  logic        wr_en_i,
  input  logic [15:0] wr_addr_i,
  input  logic [15:0] wr_data_i,
  output logic        wr_hit_o
);

  localparam int unsigned AW = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;
  localparam logic [16:0] DEPTH = 17'(MEM_WORDS);

  logic [15:0]          store_q [MEM_WORDS];
  logic [MEM_WORDS-1:0] vld_q;

  logic [15:0] ofs_a, ofs_b, ofs_w;
  logic        hit_a, hit_b;
  logic [AW-1:0] idx_a, idx_b, idx_w;

  // window offsets and hit checks
  assign ofs_a = rd_a_addr_i - base_i;
  assign ofs_b = rd_b_addr_i - base_i;
  assign ofs_w = wr_addr_i - base_i;
  assign hit_a = ({1'b0, ofs_a} < DEPTH);
  assign hit_b = ({1'b0, ofs_b} < DEPTH);
  assign wr_hit_o = ({1'b0, ofs_w} < DEPTH);
  assign idx_a = ofs_a[AW-1:0];
  assign idx_b = ofs_b[AW-1:0];
  assign idx_w = ofs_w[AW-1:0];

  // reads: outside the window or never written gives zero
  assign rd_a_data_o = (hit_a && vld_q[idx_a]) ? store_q[idx_a] : 16'h0000;
  assign rd_b_data_o = (hit_b && vld_q[idx_b]) ? store_q[idx_b] : 16'h0000;

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (wr_en_i && wr_hit_o) begin
      vld_q[idx_w] <= 1'b1;
    end
  end

  // word data
  always_ff @(posedge clk_i) begin
    if (wr_en_i && wr_hit_o) begin
      store_q[idx_w] <= wr_data_i;
    end
  end

endmodule

// ===== hw/rtl/lc3sic_regs.sv =====
// ----------------------------------------------------------------------------
// lc3sic_regs
// Eight 16-bit general registers, three read ports and one write port.
// ----------------------------------------------------------------------------
module lc3sic_regs (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [2:0]  rd_sr1_i,
  input  logic [2:0]  rd_sr2_i,
  input  logic [2:0]  rd_dr_i,
  output logic [15:0] sr1_o,
  output logic [15:0] sr2_o,
  output logic [15:0] dr_o,
  input  logic        we_i,
  input  logic [2:0]  wr_idx_i,
  input  logic [15:0] wr_data_i
);

  logic [15:0] regs_q [8];

  assign sr1_o = regs_q[rd_sr1_i];
  assign sr2_o = regs_q[rd_sr2_i];
  assign dr_o  = regs_q[rd_dr_i];

  // register write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 8; i++) begin
        regs_q[i] <= 16'h0000;
      end
    end else if (we_i) begin
      regs_q[wr_idx_i] <= wr_data_i;
    end
  end

endmodule

// ===== hw/rtl/lc3sic_exec.sv =====
// ----------------------------------------------------------------------------
// lc3sic_exec
// Decode and execute of one command item: load, set pc or one instruction.
// ----------------------------------------------------------------------------
module lc3sic_exec (
  input  logic [1:0]         kind_i,
  input  logic [15:0]        address_i,
  input  logic [15:0]        data_i,
  input  logic               halted_i,
  input  logic [15:0]        pc_i,
  input  logic [2:0]         flags_i,
  input  logic [15:0]        ir_i,
  input  logic [15:0]        sr1_i,
  input  logic [15:0]        sr2_i,
  input  logic [15:0]        dr_i,
  input  logic [15:0]        ld_data_i,
  output lc3sic_pkg::exec_t  exec_o
);

  logic [15:0] pc_inc, off9, imm5, tgt, opnd_b;
  logic [3:0]  opc;

  // field extraction
  assign opc    = ir_i[15:12];
  assign pc_inc = pc_i + 16'd1;
  assign off9   = {{7{ir_i[8]}}, ir_i[8:0]};
  assign imm5   = {{11{ir_i[4]}}, ir_i[4:0]};
  assign tgt    = pc_inc + off9;
  assign opnd_b = ir_i[5] ? imm5 : sr2_i;

  // per-kind and per-opcode behavior
  always_comb begin
    exec_o          = '0;
    exec_o.next_pc  = pc_i;
    exec_o.flags    = flags_i;
    exec_o.mem_addr = tgt;
    case (kind_i)
      lc3sic_pkg::KIND_LOAD: begin
        exec_o.mem_we   = 1'b1;
        exec_o.mem_addr = address_i;
        exec_o.mem_data = data_i;
      end
      lc3sic_pkg::KIND_SET: begin
        exec_o.next_pc = data_i;
      end
      lc3sic_pkg::KIND_STEP: begin
        if (!halted_i) begin
          exec_o.step    = 1'b1;
          exec_o.next_pc = pc_inc;
          case (opc)
            lc3sic_pkg::OP_ADD: begin
              exec_o.reg_we  = 1'b1;
              exec_o.reg_val = sr1_i + opnd_b;
            end
            lc3sic_pkg::OP_AND: begin
              exec_o.reg_we  = 1'b1;
              exec_o.reg_val = sr1_i & opnd_b;
            end
            lc3sic_pkg::OP_NOT: begin
              exec_o.reg_we  = 1'b1;
              exec_o.reg_val = ~sr1_i;
            end
            lc3sic_pkg::OP_LD: begin
              exec_o.reg_we  = 1'b1;
              exec_o.reg_val = ld_data_i;
            end
            lc3sic_pkg::OP_ST: begin
              exec_o.mem_we   = 1'b1;
              exec_o.mem_data = dr_i;
            end
            lc3sic_pkg::OP_BR: begin
              if ((ir_i[11:9] & flags_i) != 3'b000) begin
                exec_o.next_pc = tgt;
              end
            end
            lc3sic_pkg::OP_JMP: begin
              exec_o.next_pc = sr1_i;
            end
            lc3sic_pkg::OP_TRAP: begin
              exec_o.trap     = 1'b1;
              exec_o.trap_vec = ir_i[7:0];
            end
            default: begin
            end
          endcase
          // destination and condition codes of a register write
          if (exec_o.reg_we) begin
            exec_o.reg_idx = ir_i[11:9];
            exec_o.flags   = lc3sic_pkg::cc_of(exec_o.reg_val);
          end
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== hw/rtl/lc3_subset_instruction_core_top.sv =====
// ----------------------------------------------------------------------------
// lc3_subset_instruction_core_top
// LC-3 subset core: word store window, register file, one item per cycle if not stalled.
// ----------------------------------------------------------------------------
//  channel   dir  handshake     contents
//  in_i      in   valid/ready   kind, address, data
//  out_o     out  valid/ready   pc, instr, flags, halted, trap/reg/mem events
//  cfg       in   cfg_we_i      cfg_data_i -> mem_base
//
//  Fetch, decode, execute and writeback of each item happen between the
//  architectural state and the result register in a single pass.
//  A new item is taken every cycle while the result register is empty or
//  being drained; only a stalled full result register holds off the input.
//  Reset clears the word store valid bits at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
module lc3_subset_instruction_core_top #(
  parameter int unsigned MEM_WORDS = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [15:0]        cfg_data_i,
  lc3sic_in_if.sink          in_i,
  lc3sic_out_if.source       out_o
);

  logic [15:0] base_q;
  logic [15:0] pc_q;
  logic [15:0] ir_q;
  logic [2:0]  flags_q;
  logic        halt_q;
  logic        out_vld_q;

  logic [15:0] pc_d, ir_d;
  logic [2:0]  flags_d;
  logic        halt_d;

  logic [15:0] fetch_word, ld_word, sr1_val, sr2_val, dr_val;
  logic        wr_hit, in_xfer;
  lc3sic_pkg::exec_t exec;

  // result register payload
  logic [15:0] res_pc_q, res_instr_q, res_reg_value_q;
  logic [2:0]  res_flags_q, res_reg_index_q;
  logic        res_halted_q, res_reg_written_q, res_mem_written_q;
  logic [7:0]  res_trap_code_q;

  // input handshake
  assign in_i.ready = !out_vld_q || out_o.ready;
  assign in_xfer    = in_i.valid && in_i.ready;

  // word store
  lc3sic_mem #(
    .MEM_WORDS (MEM_WORDS)
  ) u_mem (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .base_i      (base_q),
    .rd_a_addr_i (pc_q),
    .rd_a_data_o (fetch_word),
    .rd_b_addr_i (exec.mem_addr),
    .rd_b_data_o (ld_word),
    .wr_en_i     (in_xfer && exec.mem_we),
    .wr_addr_i   (exec.mem_addr),
    .wr_data_i   (exec.mem_data),
    .wr_hit_o    (wr_hit)
  );

  // general registers
  lc3sic_regs u_regs (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_sr1_i  (fetch_word[8:6]),
    .rd_sr2_i  (fetch_word[2:0]),
    .rd_dr_i   (fetch_word[11:9]),
    .sr1_o     (sr1_val),
    .sr2_o     (sr2_val),
    .dr_o      (dr_val),
    .we_i      (in_xfer && exec.reg_we),
    .wr_idx_i  (exec.reg_idx),
    .wr_data_i (exec.reg_val)
  );

  // decode and execute
  lc3sic_exec u_exec (
    .kind_i    (in_i.kind),
    .address_i (in_i.address),
    .data_i    (in_i.data),
    .halted_i  (halt_q),
    .pc_i      (pc_q),
    .flags_i   (flags_q),
    .ir_i      (fetch_word),
    .sr1_i     (sr1_val),
    .sr2_i     (sr2_val),
    .dr_i      (dr_val),
    .ld_data_i (ld_word),
    .exec_o    (exec)
  );

  // next architectural state
  assign pc_d    = exec.next_pc;
  assign ir_d    = exec.step ? fetch_word : ir_q;
  assign flags_d = exec.flags;
  assign halt_d  = halt_q || exec.trap;

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= lc3sic_pkg::BASE_RESET;
    end else if (cfg_we_i) begin
      base_q <= cfg_data_i;
    end
  end

  // architectural state update on each transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q    <= lc3sic_pkg::PC_RESET;
      ir_q    <= 16'h0000;
      flags_q <= 3'b000;
      halt_q  <= 1'b0;
    end else if (in_xfer) begin
      pc_q    <= pc_d;
      ir_q    <= ir_d;
      flags_q <= flags_d;
      halt_q  <= halt_d;
    end
  end

  // result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (in_i.ready) begin
      out_vld_q <= in_i.valid;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      res_pc_q          <= pc_d;
      res_instr_q       <= ir_d;
      res_flags_q       <= flags_d;
      res_halted_q      <= halt_d;
      res_trap_code_q   <= exec.trap_vec;
      res_reg_written_q <= exec.reg_we;
      res_reg_index_q   <= exec.reg_idx;
      res_reg_value_q   <= exec.reg_val;
      res_mem_written_q <= exec.mem_we && wr_hit;
    end
  end

  // output channel
  assign out_o.valid       = out_vld_q;
  assign out_o.pc          = res_pc_q;
  assign out_o.instr       = res_instr_q;
  assign out_o.flag_n      = res_flags_q[lc3sic_pkg::CC_N];
  assign out_o.flag_z      = res_flags_q[lc3sic_pkg::CC_Z];
  assign out_o.flag_p      = res_flags_q[lc3sic_pkg::CC_P];
  assign out_o.halted      = res_halted_q;
  assign out_o.trap_code   = res_trap_code_q;
  assign out_o.reg_written = res_reg_written_q;
  assign out_o.reg_index   = res_reg_index_q;
  assign out_o.reg_value   = res_reg_value_q;
  assign out_o.mem_written = res_mem_written_q;

  // halt is only cleared by reset
  a_halt_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    halt_q |=> halt_q)
    else $error("halt flag dropped without reset");

  // at most one condition flag is ever set
  a_flags_onehot0: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(flags_q))
    else $error("more than one condition flag set");

  // a step while halted leaves pc and instruction register alone
  a_halted_step_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && halt_q && (in_i.kind == lc3sic_pkg::KIND_STEP))
      |=> (pc_q == $past(pc_q)) && (ir_q == $past(ir_q)))
    else $error("halted step changed state");

  // no register event fields without a register write
  a_reg_event_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !res_reg_written_q) |-> (res_reg_index_q == 3'd0) &&
      (res_reg_value_q == 16'h0000))
    else $error("register event fields set without a write");

endmodule
